// File: rtl/core/smpq_pkg.sv
// Package with the shared types and constants of the sorted minimum priority queue.
`default_nettype none

package smpq_pkg;

	localparam int DEF_QUEUE_DEPTH = 16;
	localparam int KEY_W           = 16;
	localparam int HANDLE_W        = 16;
	localparam int ENT_W           = KEY_W + HANDLE_W;
	localparam int STATUS_W        = 2;

	localparam logic REQ_PUSH = 1'b0;
	localparam logic REQ_POP  = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PUSH_WALK,
		ST_PUT,
		ST_POP_WALK,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

// File: rtl/core/sorted_min_priority_queue_top.sv
// Sorted minimum priority queue with one shared compare and move unit over a list memory.
//
// The input channel carries one request per handshake: a push of a key and a handle, or a
// pop of the smallest entry. A request is taken when in_valid is high and in_stall is low.
// The block takes one request at a time and holds in_stall high while it works on it.
// Each request gives exactly one result on the output channel: the smallest key and handle
// after the request, the empty flag, the entry count and a status code.
// A push walks the list from its tail, one stored entry per cycle, moving every entry with
// a greater key up by one slot, then writes the new entry: ST_IDLE accepts it, ST_PUSH_WALK
// steps over any stored entries, ST_PUT writes the new one and ST_DONE loads the result.
// A pop on n entries moves the remaining n - 1 entries down by one slot, one per cycle, in
// ST_POP_WALK (skipped when n is one), then loads its result in ST_DONE. A push to a full
// queue or a pop on an empty queue goes straight from ST_IDLE to ST_DONE to load its result.
// The next request is taken in the cycle after the result is loaded.
// The pace is set by the single read port of the list memory and the one compare unit.
// The result sits in an output register; a new request is taken while it waits.
// When the receiver stalls, a finished request waits for the output register to be free.
// Reset empties the queue and drops any pending result; no clearing pass is needed.
`default_nettype none

module sorted_min_priority_queue_top #(
	parameter int QUEUE_DEPTH = smpq_pkg::DEF_QUEUE_DEPTH,
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output      logic                          in_stall,
	input  wire logic                          req_type,
	input  wire logic [smpq_pkg::KEY_W-1:0]    entry_key,
	input  wire logic [smpq_pkg::HANDLE_W-1:0] entry_handle,
	output      logic                          out_valid,
	input  wire logic                          out_stall,
	output      logic [smpq_pkg::KEY_W-1:0]    min_key,
	output      logic [smpq_pkg::HANDLE_W-1:0] min_handle,
	output      logic                          is_empty,
	output      logic [CNT_W-1:0]              entry_count,
	output      logic [smpq_pkg::STATUS_W-1:0] status
);
	import smpq_pkg::*;

	localparam int IDX_W = $clog2(QUEUE_DEPTH);

	state_t state_q, state_d;

	logic [ENT_W-1:0]    mem [QUEUE_DEPTH];
	logic [ENT_W-1:0]    rd_q;
	logic [IDX_W-1:0]    rd_addr;
	logic                wr_en;
	logic [IDX_W-1:0]    wr_addr;
	logic [ENT_W-1:0]    wr_data;

	logic [IDX_W-1:0]    idx_q, idx_d;
	logic [IDX_W-1:0]    put_q, put_d;
	logic [CNT_W-1:0]    occ_q, occ_d;
	logic [CNT_W-1:0]    occ_m1;
	logic [STATUS_W-1:0] status_q, status_d;
	logic [KEY_W-1:0]    key_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [KEY_W-1:0]    head_key_q;
	logic [HANDLE_W-1:0] head_handle_q;
	logic [KEY_W-1:0]    rd_key;
	logic                accept;
	logic                load_out;

	logic                out_valid_q;
	logic [KEY_W-1:0]    min_key_q;
	logic [HANDLE_W-1:0] min_handle_q;
	logic                is_empty_q;
	logic [CNT_W-1:0]    entry_count_q;
	logic [STATUS_W-1:0] status_out_q;

	assign occ_m1   = occ_q - CNT_W'(1);
	assign rd_key   = rd_q[ENT_W-1 -: KEY_W];
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && (state_q == ST_IDLE);

	always_comb begin
		state_d  = state_q;
		idx_d    = idx_q;
		put_d    = put_q;
		occ_d    = occ_q;
		status_d = status_q;
		rd_addr  = idx_q;
		wr_en    = 1'b0;
		wr_addr  = idx_q;
		wr_data  = rd_q;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					status_d = STATUS_OK;
					if (req_type == REQ_PUSH) begin
						if (occ_q == CNT_W'(QUEUE_DEPTH)) begin
							status_d = STATUS_FULL;
							state_d  = ST_DONE;
						end else if (occ_q == '0) begin
							put_d   = '0;
							state_d = ST_PUT;
						end else begin
							rd_addr = occ_m1[IDX_W-1:0];
							idx_d   = occ_m1[IDX_W-1:0];
							state_d = ST_PUSH_WALK;
						end
					end else begin
						if (occ_q == '0) begin
							status_d = STATUS_EMPTY;
							state_d  = ST_DONE;
						end else if (occ_q == CNT_W'(1)) begin
							occ_d   = occ_m1;
							state_d = ST_DONE;
						end else begin
							rd_addr = IDX_W'(1);
							idx_d   = IDX_W'(1);
							state_d = ST_POP_WALK;
						end
					end
				end
			end
			ST_PUSH_WALK: begin
				if (rd_key > key_q) begin
					wr_en   = 1'b1;
					wr_addr = idx_q + IDX_W'(1);
					if (idx_q == '0) begin
						put_d   = '0;
						state_d = ST_PUT;
					end else begin
						idx_d   = idx_q - IDX_W'(1);
						rd_addr = idx_q - IDX_W'(1);
					end
				end else begin
					put_d   = idx_q + IDX_W'(1);
					state_d = ST_PUT;
				end
			end
			ST_PUT: begin
				wr_en   = 1'b1;
				wr_addr = put_q;
				wr_data = {key_q, handle_q};
				occ_d   = occ_q + CNT_W'(1);
				state_d = ST_DONE;
			end
			ST_POP_WALK: begin
				wr_en   = 1'b1;
				wr_addr = idx_q - IDX_W'(1);
				if (CNT_W'(idx_q) == occ_m1) begin
					occ_d   = occ_m1;
					state_d = ST_DONE;
				end else begin
					idx_d   = idx_q + IDX_W'(1);
					rd_addr = idx_q + IDX_W'(1);
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			occ_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			occ_q   <= occ_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q    <= idx_d;
		put_q    <= put_d;
		status_q <= status_d;
		if (accept) begin
			key_q    <= entry_key;
			handle_q <= entry_handle;
		end
		if (wr_en && (wr_addr == '0)) begin
			head_key_q    <= wr_data[ENT_W-1 -: KEY_W];
			head_handle_q <= wr_data[HANDLE_W-1:0];
		end
		if (load_out) begin
			is_empty_q    <= (occ_q == '0);
			min_key_q     <= (occ_q == '0) ? '0 : head_key_q;
			min_handle_q  <= (occ_q == '0) ? '0 : head_handle_q;
			entry_count_q <= occ_q;
			status_out_q  <= status_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	assign out_valid   = out_valid_q;
	assign min_key     = min_key_q;
	assign min_handle  = min_handle_q;
	assign is_empty    = is_empty_q;
	assign entry_count = entry_count_q;
	assign status      = status_out_q;

endmodule

`default_nettype wire

// File: bench/sorted_min_priority_queue_top_test.sv
// Self-checking testbench for the sorted minimum priority queue with random handshake gaps.
module sorted_min_priority_queue_top_test;
	import smpq_pkg::*;

	localparam int CNT_W       = $clog2(DEF_QUEUE_DEPTH + 1);
	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_REQS = 1730;

	typedef struct {
		logic                op;
		logic [KEY_W-1:0]    key;
		logic [HANDLE_W-1:0] handle;
		bit                  wait_idle;
	} pq_request_t;

	typedef struct {
		logic [KEY_W-1:0]    min_key;
		logic [HANDLE_W-1:0] min_handle;
		logic                is_empty;
		logic [CNT_W-1:0]    entry_count;
		logic [STATUS_W-1:0] status;
	} pq_result_t;

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                in_valid     = 1'b0;
	logic                in_stall;
	logic                req_type     = REQ_PUSH;
	logic [KEY_W-1:0]    entry_key    = '0;
	logic [HANDLE_W-1:0] entry_handle = '0;
	logic                out_valid;
	logic                out_stall    = 1'b0;
	logic [KEY_W-1:0]    min_key;
	logic [HANDLE_W-1:0] min_handle;
	logic                is_empty;
	logic [CNT_W-1:0]    entry_count;
	logic [STATUS_W-1:0] status;

	pq_request_t pending_reqs[$];
	pq_request_t next_req;
	pq_result_t  expected_results[$];
	pq_result_t  seen_result;
	pq_result_t  wanted_result;

	logic [KEY_W-1:0]    queue_keys[DEF_QUEUE_DEPTH];
	logic [HANDLE_W-1:0] queue_handles[DEF_QUEUE_DEPTH];
	int queue_fill = 0;

	int requests_sent  = 0;
	int results_seen   = 0;
	int total_requests = 0;
	int mismatches     = 0;
	int cycle_count    = 0;
	int send_gap       = 0;
	int stall_left     = 0;
	bit send_calm      = 1'b0;
	bit recv_calm      = 1'b0;

	sorted_min_priority_queue_top u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.entry_key   (entry_key),
		.entry_handle(entry_handle),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.min_key     (min_key),
		.min_handle  (min_handle),
		.is_empty    (is_empty),
		.entry_count (entry_count),
		.status      (status)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic pq_result_t apply_request(logic op, logic [KEY_W-1:0] key,
			logic [HANDLE_W-1:0] handle);
		pq_result_t r;
		int slot;
		r.status = STATUS_OK;
		if (op == REQ_PUSH) begin
			if (queue_fill >= DEF_QUEUE_DEPTH) begin
				r.status = STATUS_FULL;
			end else begin
				slot = queue_fill;
				for (int i = queue_fill - 1; i >= 0; i--)
					if (queue_keys[i] > key)
						slot = i;
				for (int i = queue_fill; i > slot; i--) begin
					queue_keys[i]    = queue_keys[i - 1];
					queue_handles[i] = queue_handles[i - 1];
				end
				queue_keys[slot]    = key;
				queue_handles[slot] = handle;
				queue_fill++;
			end
		end else begin
			if (queue_fill == 0) begin
				r.status = STATUS_EMPTY;
			end else begin
				for (int i = 1; i < queue_fill; i++) begin
					queue_keys[i - 1]    = queue_keys[i];
					queue_handles[i - 1] = queue_handles[i];
				end
				queue_fill--;
			end
		end
		r.is_empty    = (queue_fill == 0);
		r.min_key     = r.is_empty ? '0 : queue_keys[0];
		r.min_handle  = r.is_empty ? '0 : queue_handles[0];
		r.entry_count = queue_fill[CNT_W-1:0];
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return $urandom_range(1, 2);
		else if (r < 92)
			return $urandom_range(3, 6);
		return $urandom_range(15, 50);
	endfunction

	function automatic logic [KEY_W-1:0] pick_key();
		case ($urandom_range(0, 9))
			0, 1, 2: return KEY_W'($urandom_range(0, 7));
			3:       return '0;
			4:       return '1;
			5:       return KEY_W'($urandom_range(16'hFFF8, 16'hFFFF));
			default: return KEY_W'($urandom_range(0, 16'hFFFF));
		endcase
	endfunction

	task automatic add_request(logic op, logic [KEY_W-1:0] key, logic [HANDLE_W-1:0] handle,
			bit wait_idle);
		pq_request_t req;
		req.op        = op;
		req.key       = key;
		req.handle    = handle;
		req.wait_idle = wait_idle;
		pending_reqs.insert(pending_reqs.size(), req);
	endtask

	task automatic report_mismatch(string field, logic [15:0] want, logic [15:0] got);
		$display("%0t: %s expected %0h actual %0h", $time, field, want, got);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid      <= 1'b0;
			send_gap      = 0;
			requests_sent = 0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_results.insert(expected_results.size(),
					apply_request(req_type, entry_key, entry_handle));
				requests_sent++;
				send_gap = (send_calm || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
			end
			if ($urandom_range(0, 199) == 0)
				send_calm = !send_calm;
			if (in_valid && in_stall) begin
			end else if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (pending_reqs.size() != 0 &&
					!(pending_reqs[0].wait_idle && requests_sent != results_seen)) begin
				next_req = pending_reqs[0];
				pending_reqs.delete(0);
				in_valid     <= 1'b1;
				req_type     <= next_req.op;
				entry_key    <= next_req.key;
				entry_handle <= next_req.handle;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall    <= 1'b0;
			results_seen <= 0;
			stall_left   = 0;
		end else begin
			if (out_valid && !out_stall) begin
				seen_result = '{min_key, min_handle, is_empty, entry_count, status};
				if (expected_results.size() == 0) begin
					$display("%0t: result with no request pending, min_key %0h", $time, min_key);
					mismatches++;
				end else begin
					wanted_result = expected_results[0];
					expected_results.delete(0);
					if (seen_result.min_key !== wanted_result.min_key)
						report_mismatch("min_key", wanted_result.min_key, seen_result.min_key);
					if (seen_result.min_handle !== wanted_result.min_handle)
						report_mismatch("min_handle", wanted_result.min_handle,
							seen_result.min_handle);
					if (seen_result.is_empty !== wanted_result.is_empty)
						report_mismatch("is_empty", 16'(wanted_result.is_empty),
							16'(seen_result.is_empty));
					if (seen_result.entry_count !== wanted_result.entry_count)
						report_mismatch("entry_count", 16'(wanted_result.entry_count),
							16'(seen_result.entry_count));
					if (seen_result.status !== wanted_result.status)
						report_mismatch("status", 16'(wanted_result.status),
							16'(seen_result.status));
				end
				results_seen <= results_seen + 1;
				// A long hold-off lets the block fill up and stall its input.
				if (results_seen == 300 || results_seen == 1100)
					stall_left = 120;
			end
			if ($urandom_range(0, 199) == 0)
				recv_calm = !recv_calm;
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (!recv_calm && $urandom_range(0, 3) == 0) begin
				stall_left = pick_gap() - 1;
				out_stall  <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		int random_left;
		int push_pct;
		int run_len;
		logic op;

		add_request(REQ_POP, 16'h1234, 16'h5678, 1'b0);
		add_request(REQ_PUSH, 16'hFFFF, 16'hFFFF, 1'b0);
		add_request(REQ_PUSH, 16'h0000, 16'h0000, 1'b0);
		add_request(REQ_PUSH, 16'h8000, 16'h0001, 1'b0);
		add_request(REQ_PUSH, 16'h8000, 16'h0002, 1'b0);
		add_request(REQ_PUSH, 16'h8000, 16'h0003, 1'b0);
		for (int i = 0; i < 11; i++)
			add_request(REQ_PUSH, KEY_W'(16'h7FFF - i), HANDLE_W'($urandom), 1'b0);
		add_request(REQ_PUSH, 16'h0000, 16'hAAAA, 1'b0);
		add_request(REQ_POP, 16'hFFFF, 16'hFFFF, 1'b0);
		add_request(REQ_PUSH, 16'hFFFF, 16'h5555, 1'b0);
		add_request(REQ_PUSH, 16'h0000, 16'hFFFF, 1'b0);

		// Episodes with a mix of pushes and pops reach both the full and the empty queue.
		random_left = RANDOM_REQS;
		while (random_left > 0) begin
			case ($urandom_range(0, 3))
				0:       push_pct = 20;
				1:       push_pct = 50;
				2:       push_pct = 80;
				default: push_pct = 97;
			endcase
			run_len = $urandom_range(10, 60);
			for (int k = 0; k < run_len && random_left > 0; k++) begin
				op = ($urandom_range(0, 99) < push_pct) ? REQ_PUSH : REQ_POP;
				add_request(op, pick_key(), HANDLE_W'($urandom),
					random_left == RANDOM_REQS || $urandom_range(0, 299) == 0);
				random_left--;
			end
		end
		total_requests = pending_reqs.size();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		wait (requests_sent == total_requests);
		wait (results_seen == requests_sent);
		repeat (40) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
